### sv/sparse_memory_with_static_region_unit_macros.svh
// ---------------------------------------------------------------------------
// sparse memory unit assertion macros
// concurrent assertion shorthands used by the unit's back module
// ---------------------------------------------------------------------------
`ifndef SPARSE_MEMORY_WITH_STATIC_REGION_UNIT_MACROS_SVH
`define SPARSE_MEMORY_WITH_STATIC_REGION_UNIT_MACROS_SVH

// same-cycle implication
`define SMSR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smsr: same-cycle check failed");

// next-cycle implication
`define SMSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smsr: next-cycle check failed");

`endif

### sv/smsr_pkg.sv
// ---------------------------------------------------------------------------
// sparse memory unit package
// sizes, codes and item types shared by front, queue and back
// ---------------------------------------------------------------------------
package smsr_pkg;

  // storage sizes
  localparam int STATIC_DEPTH = 1024;
  localparam int DYN_ENTRIES  = 64;
  localparam int SIDX_W       = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
  localparam int DIDX_W       = (DYN_ENTRIES > 1) ? $clog2(DYN_ENTRIES) : 1;

  // field widths
  localparam int SIZE_W = 11;
  localparam int ADDR_W = 32;
  localparam int WORD_W = 32;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NODELETE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMP,
    ST_ENC,
    ST_ACC,
    ST_RESP
  } state_t;

  // classified item as it travels through the queue
  typedef struct packed {
    func_t                    func;
    logic [ADDR_W-1:0]        address;
    logic signed [WORD_W-1:0] write_data;
    logic                     is_static;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

### sv/smsr_front.sv
// ---------------------------------------------------------------------------
// sparse memory front
// accepts items, splits the address space into static and dynamic region
// ---------------------------------------------------------------------------
module smsr_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // address, write_data
  input  logic [1:0]                      s_tuser,   // func
  input  logic [smsr_pkg::SIZE_W-1:0]     static_size,
  input  smsr_pkg::queue_status_t         q_status,
  input  smsr_pkg::back_status_t          b_status,
  output logic                            push,
  output smsr_pkg::item_t                 push_item
);

  logic [smsr_pkg::ADDR_W-1:0] size_raw;
  logic [smsr_pkg::ADDR_W-1:0] size_eff;

  // clamp the configured size to the store depth
  assign size_raw = smsr_pkg::ADDR_W'(static_size);
  assign size_eff = (size_raw > smsr_pkg::ADDR_W'(smsr_pkg::STATIC_DEPTH))
                    ? smsr_pkg::ADDR_W'(smsr_pkg::STATIC_DEPTH) : size_raw;

  // accept while the queue has room and the store is not being cleared
  assign s_tready = !q_status.full && !b_status.clearing;
  assign push     = s_tvalid && s_tready;

  // classify the item
  always_comb begin
    push_item.func       = smsr_pkg::func_t'(s_tuser);
    push_item.address    = s_tdata[31:0];
    push_item.write_data = s_tdata[63:32];
    push_item.is_static  = s_tdata[31:0] < size_eff;
  end

endmodule

### sv/smsr_queue.sv
// ---------------------------------------------------------------------------
// sparse memory item queue
// short fifo that lets front and back stall independently
// ---------------------------------------------------------------------------
module smsr_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  smsr_pkg::item_t         push_item,
  input  logic                    pop,
  output smsr_pkg::item_t         pop_item,
  output smsr_pkg::queue_status_t q_status
);

  smsr_pkg::item_t                slots [smsr_pkg::QUEUE_DEPTH];
  logic [smsr_pkg::QPTR_W-1:0]    wr_ptr;
  logic [smsr_pkg::QPTR_W-1:0]    rd_ptr;
  logic [smsr_pkg::QCNT_W-1:0]    count;

  function automatic logic [smsr_pkg::QPTR_W-1:0] ptr_inc(
    input logic [smsr_pkg::QPTR_W-1:0] p
  );
    if (p == smsr_pkg::QPTR_W'(smsr_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign q_status.full  = (count == smsr_pkg::QCNT_W'(smsr_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_item       = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/smsr_back.sv
// ---------------------------------------------------------------------------
// sparse memory back
// clears the static store, looks items up, updates storage, holds results
// ---------------------------------------------------------------------------
`include "sparse_memory_with_static_region_unit_macros.svh"

module smsr_back (
  input  logic                    clk,
  input  logic                    rst,
  input  smsr_pkg::queue_status_t q_status,
  input  smsr_pkg::item_t         pop_item,
  output logic                    pop,
  output smsr_pkg::back_status_t  b_status,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [31:0]             m_tdata,   // read_data
  output logic [3:0]              m_tuser    // status[1:0], cell_exists, in_dynamic_region
);

  localparam int N = smsr_pkg::DYN_ENTRIES;

  smsr_pkg::state_t state;
  smsr_pkg::state_t state_next;
  smsr_pkg::item_t  item;

  // storage
  logic [smsr_pkg::WORD_W-1:0] static_mem [smsr_pkg::STATIC_DEPTH];
  logic [smsr_pkg::WORD_W-1:0] entry_word [N];
  logic [smsr_pkg::ADDR_W-1:0] entry_address [N];
  logic [N-1:0]                entry_valid;

  logic [smsr_pkg::SIDX_W-1:0] clr_cnt;
  logic [N-1:0]                hit_vec;
  logic [N-1:0]                hit_vec_next;
  logic [N-1:0]                free_vec;
  logic                        hit_any;
  logic                        free_any;
  logic [smsr_pkg::DIDX_W-1:0] hit_idx;
  logic [smsr_pkg::DIDX_W-1:0] free_idx;

  // memory port controls
  logic                        st_we;
  logic [smsr_pkg::SIDX_W-1:0] st_waddr;
  logic [smsr_pkg::WORD_W-1:0] st_wdata;
  logic                        st_re;
  logic [smsr_pkg::WORD_W-1:0] st_rdata;
  logic                        ew_we;
  logic [smsr_pkg::DIDX_W-1:0] ew_waddr;
  logic                        ew_re;
  logic [smsr_pkg::WORD_W-1:0] ew_rdata;
  logic                        alloc;
  logic                        del_hit;

  // result
  logic                        out_load;
  logic                        out_valid;
  logic [31:0]                 out_data;
  logic [3:0]                  out_user;
  logic [smsr_pkg::WORD_W-1:0] rd_word;
  smsr_pkg::status_t           rd_status;

  function automatic logic [smsr_pkg::DIDX_W-1:0] first_set(input logic [N-1:0] v);
    logic [smsr_pkg::DIDX_W-1:0] idx;
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = smsr_pkg::DIDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign b_status.clearing = (state == smsr_pkg::ST_CLEAR);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  // parallel tag compare, static addresses never hit the table
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_vec_next[i] = entry_valid[i] && (entry_address[i] == item.address)
                        && !item.is_static;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smsr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and port controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    st_we      = 1'b0;
    st_waddr   = item.address[smsr_pkg::SIDX_W-1:0];
    st_wdata   = item.write_data;
    st_re      = 1'b0;
    ew_we      = 1'b0;
    ew_waddr   = hit_idx;
    ew_re      = 1'b0;
    alloc      = 1'b0;
    del_hit    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      smsr_pkg::ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_cnt;
        st_wdata = '0;
        if (clr_cnt == smsr_pkg::SIDX_W'(smsr_pkg::STATIC_DEPTH - 1)) begin
          state_next = smsr_pkg::ST_IDLE;
        end
      end
      smsr_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = smsr_pkg::ST_CMP;
        end
      end
      smsr_pkg::ST_CMP: begin
        st_re      = item.is_static;
        state_next = smsr_pkg::ST_ENC;
      end
      smsr_pkg::ST_ENC: begin
        state_next = smsr_pkg::ST_ACC;
      end
      smsr_pkg::ST_ACC: begin
        unique case (item.func)
          smsr_pkg::FUNC_READ: begin
            ew_re = hit_any;
          end
          smsr_pkg::FUNC_WRITE: begin
            if (item.is_static) begin
              st_we = 1'b1;
            end else if (hit_any) begin
              ew_we = 1'b1;
            end else if (free_any) begin
              ew_we    = 1'b1;
              ew_waddr = free_idx;
              alloc    = 1'b1;
            end
          end
          smsr_pkg::FUNC_DELETE: begin
            del_hit = hit_any;
          end
          smsr_pkg::FUNC_QUERY: begin
          end
        endcase
        state_next = smsr_pkg::ST_RESP;
      end
      smsr_pkg::ST_RESP: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = smsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smsr_pkg::ST_IDLE;
      end
    endcase
  end

  // result word and status
  always_comb begin
    rd_word   = '0;
    rd_status = smsr_pkg::STATUS_OK;
    unique case (item.func)
      smsr_pkg::FUNC_READ: begin
        if (item.is_static) begin
          rd_word = st_rdata;
        end else if (hit_any) begin
          rd_word = ew_rdata;
        end else begin
          rd_status = smsr_pkg::STATUS_INVALID;
        end
      end
      smsr_pkg::FUNC_WRITE: begin
        if (!item.is_static && !hit_any && !free_any) begin
          rd_status = smsr_pkg::STATUS_FULL;
        end
      end
      smsr_pkg::FUNC_DELETE: begin
        if (item.is_static) begin
          rd_status = smsr_pkg::STATUS_NODELETE;
        end
      end
      smsr_pkg::FUNC_QUERY: begin
      end
    endcase
  end

  // clear counter and lookup vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hit_vec <= '0;
    end else begin
      if (state == smsr_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == smsr_pkg::ST_CMP) begin
        hit_vec <= hit_vec_next;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      item <= '0;
    end else if (pop) begin
      item <= pop_item;
    end
  end

  // free vector and encoded indexes
  always_ff @(posedge clk) begin
    if (state == smsr_pkg::ST_CMP) begin
      free_vec <= ~entry_valid;
    end
    if (state == smsr_pkg::ST_ENC) begin
      hit_any  <= |hit_vec;
      hit_idx  <= first_set(hit_vec);
      free_any <= |free_vec;
      free_idx <= first_set(free_vec);
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (alloc) begin
      entry_valid[free_idx] <= 1'b1;
    end else if (del_hit) begin
      entry_valid[hit_idx] <= 1'b0;
    end
  end

  // entry tags
  always_ff @(posedge clk) begin
    if (alloc) begin
      entry_address[free_idx] <= item.address;
    end
  end

  // static store
  always_ff @(posedge clk) begin
    if (st_we) begin
      static_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata <= static_mem[item.address[smsr_pkg::SIDX_W-1:0]];
    end
  end

  // dynamic entry words
  always_ff @(posedge clk) begin
    if (ew_we) begin
      entry_word[ew_waddr] <= item.write_data;
    end
    if (ew_re) begin
      ew_rdata <= entry_word[hit_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= rd_word;
      out_user <= {!item.is_static, item.is_static || hit_any, rd_status};
    end
  end

  // checks
  `SMSR_ASSERT_IMP(a_no_pop_clear, clk, rst, state == smsr_pkg::ST_CLEAR, !pop)
  `SMSR_ASSERT_IMP(a_hit_unique, clk, rst, 1'b1, $onehot0(hit_vec))
  `SMSR_ASSERT_NEXT(a_alloc_sets, clk, rst, alloc, entry_valid[$past(free_idx)])
  `SMSR_ASSERT_NEXT(a_delete_frees, clk, rst, del_hit, !entry_valid[$past(hit_idx)])

endmodule

### sv/sparse_memory_with_static_region_unit.sv
// ---------------------------------------------------------------------------
// sparse memory with static region
// word memory split into a cleared static store and an associative table
// ---------------------------------------------------------------------------
// Usage:
//  - items arrive on s_tvalid/s_tready: s_tuser carries the operation
//    (read, write, delete, query), s_tdata the address and the write word
//  - every item gives exactly one result on m_tvalid/m_tready: m_tdata the
//    word read, m_tuser the status, cell-exists and dynamic-region flags
//  - cfg_we/cfg_wdata write the static size; write it only while idle
//  - addresses below the static size go to the direct store, others to a
//    table of 64 tagged entries with lowest-free allocation on a write miss
//  - each item passes in order through the back sequencer steps (pop, tag
//    compare, index encode, storage access, result load), and the back
//    pops no new item until the last one is in the result register
//  - a two-item queue sits between the accepting front and the back, and a
//    result register holds the finished item; when the receiver stalls the
//    back waits on that register and the queue fills, then s_tready drops
//  - after rst the static store is cleared one word a cycle, all 1024 words,
//    with s_tready low; table valid bits and static size clear at once
// ---------------------------------------------------------------------------
module sparse_memory_with_static_region_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // address[31:0], write_data[63:32]
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_data
  output logic [3:0]  m_tuser,   // status[1:0], cell_exists, in_dynamic_region
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  logic [smsr_pkg::SIZE_W-1:0] static_size;
  smsr_pkg::queue_status_t     q_status;
  smsr_pkg::back_status_t      b_status;
  logic                        push;
  smsr_pkg::item_t             push_item;
  logic                        pop;
  smsr_pkg::item_t             pop_item;

  // static size register
  always_ff @(posedge clk) begin
    if (rst) begin
      static_size <= '0;
    end else if (cfg_we) begin
      static_size <= cfg_wdata;
    end
  end

  smsr_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .static_size (static_size),
    .q_status    (q_status),
    .b_status    (b_status),
    .push        (push),
    .push_item   (push_item)
  );

  smsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  smsr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_item (pop_item),
    .pop      (pop),
    .b_status (b_status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### test/sparse_memory_with_static_region_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sparse memory with static region testbench
// drives read, write, delete and query items through the stream port under
// several static sizes; a local memory model predicts every result and a
// monitor compares each field; both sides idle at random
// ---------------------------------------------------------------------------
module sparse_memory_with_static_region_unit_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    smsr_pkg::func_t                    func;
    logic [smsr_pkg::ADDR_W-1:0]        address;
    logic signed [smsr_pkg::WORD_W-1:0] write_data;
  } mem_access_t;

  typedef struct packed {
    logic signed [smsr_pkg::WORD_W-1:0] read_data;
    smsr_pkg::status_t                  status;
    logic                               cell_exists;
    logic                               in_dynamic;
  } mem_result_t;

  // dut ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // address[31:0], write_data[63:32]
  logic [1:0]  s_tuser = '0;   // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // read_data
  logic [3:0]  m_tuser;        // status[1:0], cell_exists, in_dynamic_region
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  // memory model state
  logic [smsr_pkg::SIZE_W-1:0] static_size_model;
  logic [smsr_pkg::WORD_W-1:0] static_mem [smsr_pkg::STATIC_DEPTH];
  logic                        tag_valid  [smsr_pkg::DYN_ENTRIES];
  logic [smsr_pkg::ADDR_W-1:0] tag_addr   [smsr_pkg::DYN_ENTRIES];
  logic [smsr_pkg::WORD_W-1:0] tag_word   [smsr_pkg::DYN_ENTRIES];

  mem_access_t pending_accesses [$];
  mem_result_t expected_results [$];
  mem_access_t cur_access;
  int sent_count  = 0;
  int done_count  = 0;
  int error_count = 0;
  int send_gap    = 0;
  int send_quiet  = 0;
  int recv_stall  = 0;
  int recv_quiet  = 0;

  sparse_memory_with_static_region_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock, period 4 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle length per item, with occasional stretches of no idling
  function automatic int idle_cycles(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  // expected result of one access, updates the model memory
  function automatic mem_result_t memory_access(mem_access_t acc);
    mem_result_t res;
    logic [31:0] eff_size;
    logic        is_static;
    int          hit;
    int          free_slot;
    eff_size  = (static_size_model > smsr_pkg::STATIC_DEPTH)
                ? smsr_pkg::STATIC_DEPTH : static_size_model;
    is_static = acc.address < eff_size;
    hit       = -1;
    free_slot = -1;
    if (!is_static) begin
      for (int i = 0; i < smsr_pkg::DYN_ENTRIES; i++) begin
        if (tag_valid[i] && tag_addr[i] == acc.address && hit < 0) hit = i;
        if (!tag_valid[i] && free_slot < 0) free_slot = i;
      end
    end
    res.read_data   = '0;
    res.status      = smsr_pkg::STATUS_OK;
    res.cell_exists = is_static || (hit >= 0);
    res.in_dynamic  = !is_static;
    case (acc.func)
      smsr_pkg::FUNC_READ: begin
        if (is_static) res.read_data = static_mem[acc.address[smsr_pkg::SIDX_W-1:0]];
        else if (hit >= 0) res.read_data = tag_word[hit];
        else res.status = smsr_pkg::STATUS_INVALID;
      end
      smsr_pkg::FUNC_WRITE: begin
        if (is_static) static_mem[acc.address[smsr_pkg::SIDX_W-1:0]] = acc.write_data;
        else if (hit >= 0) tag_word[hit] = acc.write_data;
        else if (free_slot >= 0) begin
          tag_valid[free_slot] = 1'b1;
          tag_addr[free_slot]  = acc.address;
          tag_word[free_slot]  = acc.write_data;
        end else res.status = smsr_pkg::STATUS_FULL;
      end
      smsr_pkg::FUNC_DELETE: begin
        if (is_static) res.status = smsr_pkg::STATUS_NODELETE;
        else if (hit >= 0) tag_valid[hit] = 1'b0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // driver: present pending items, predict on accept
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(memory_access(cur_access));
      if (!s_tvalid || s_tready) begin
        if (send_gap == 0 && pending_accesses.size() > 0) begin
          cur_access <= pending_accesses[0];
          s_tdata    <= {pending_accesses[0].write_data, pending_accesses[0].address};
          s_tuser    <= pending_accesses[0].func;
          s_tvalid   <= 1'b1;
          send_gap   <= idle_cycles(send_quiet);
          void'(pending_accesses.pop_front());
        end else begin
          s_tvalid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    mem_result_t exp_res;
    int          stall;
    if (rst) begin
      m_tready   <= 1'b0;
      recv_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      done_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no expectation, actual data %h user %h",
                 $time, m_tdata, m_tuser);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (m_tdata !== exp_res.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, exp_res.read_data, m_tdata);
          error_count++;
        end
        if (m_tuser[1:0] !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, m_tuser[1:0]);
          error_count++;
        end
        if (m_tuser[2] !== exp_res.cell_exists) begin
          $display("%0t: cell_exists expected %b actual %b",
                   $time, exp_res.cell_exists, m_tuser[2]);
          error_count++;
        end
        if (m_tuser[3] !== exp_res.in_dynamic) begin
          $display("%0t: in_dynamic_region expected %b actual %b",
                   $time, exp_res.in_dynamic, m_tuser[3]);
          error_count++;
        end
      end
      stall = idle_cycles(recv_quiet);
      recv_stall <= stall;
      m_tready   <= (stall == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready   <= (recv_stall == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted item or result
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic queue_access(smsr_pkg::func_t func, logic [31:0] address,
                              logic [31:0] data);
    mem_access_t acc;
    acc.func       = func;
    acc.address    = address;
    acc.write_data = data;
    pending_accesses.push_back(acc);
    sent_count++;
  endtask

  task automatic wait_idle();
    while (done_count != sent_count) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic set_static_size(logic [smsr_pkg::SIZE_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we            <= 1'b0;
    static_size_model = value;
    @(negedge clk);
  endtask

  // random mix around the static boundary, the top of memory and the table
  task automatic queue_random(int count, logic [smsr_pkg::SIZE_W-1:0] size_value);
    int              eff_size;
    int              pick;
    smsr_pkg::func_t func;
    logic [31:0]     address;
    eff_size = (size_value > smsr_pkg::STATIC_DEPTH) ? smsr_pkg::STATIC_DEPTH : size_value;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) func = smsr_pkg::FUNC_WRITE;
      else if (pick < 65) func = smsr_pkg::FUNC_READ;
      else if (pick < 80) func = smsr_pkg::FUNC_DELETE;
      else func = smsr_pkg::FUNC_QUERY;
      pick = $urandom_range(0, 99);
      if (eff_size > 0 && pick < 30) address = $urandom_range(0, eff_size - 1);
      else if (pick < 65) address = eff_size + $urandom_range(0, 47);
      else if (pick < 82) address = 32'hFFFF_FFFF - $urandom_range(0, 31);
      else if (pick < 92) address = $urandom_range(0, 1100);
      else address = $urandom;
      queue_access(func, address, $urandom);
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [smsr_pkg::SIZE_W-1:0] size_value;
    for (int i = 0; i < smsr_pkg::STATIC_DEPTH; i++) static_mem[i] = '0;
    for (int i = 0; i < smsr_pkg::DYN_ENTRIES; i++) begin
      tag_valid[i] = 1'b0;
      tag_addr[i]  = '0;
      tag_word[i]  = '0;
    end
    static_size_model = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed accesses with a small static region
    set_static_size(11'd16);
    queue_access(smsr_pkg::FUNC_READ,   32'd0,  32'h0);
    queue_access(smsr_pkg::FUNC_READ,   32'd15, 32'h0);
    queue_access(smsr_pkg::FUNC_WRITE,  32'd0,  32'h7FFF_FFFF);
    queue_access(smsr_pkg::FUNC_READ,   32'd0,  32'h0);
    queue_access(smsr_pkg::FUNC_WRITE,  32'd15, 32'h8000_0000);
    queue_access(smsr_pkg::FUNC_READ,   32'd15, 32'hFFFF_FFFF);
    queue_access(smsr_pkg::FUNC_DELETE, 32'd0,  32'h0);
    queue_access(smsr_pkg::FUNC_QUERY,  32'd15, 32'h0);
    queue_access(smsr_pkg::FUNC_READ,   32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_QUERY,  32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_DELETE, 32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_WRITE,  32'd16, 32'hFFFF_FFFF);
    queue_access(smsr_pkg::FUNC_READ,   32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_QUERY,  32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_WRITE,  32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_READ,   32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_DELETE, 32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_READ,   32'd16, 32'h0);
    queue_access(smsr_pkg::FUNC_WRITE,  32'hFFFF_FFFF, 32'h5A5A_5A5A);
    queue_access(smsr_pkg::FUNC_READ,   32'hFFFF_FFFF, 32'h0);
    queue_access(smsr_pkg::FUNC_WRITE,  32'h8000_0000, 32'h0);
    queue_access(smsr_pkg::FUNC_QUERY,  32'hFFFF_FFFF, 32'h0);
    queue_access(smsr_pkg::FUNC_DELETE, 32'hFFFF_FFFF, 32'h0);
    queue_access(smsr_pkg::FUNC_READ,   32'h8000_0000, 32'h0);
    queue_random(120, 11'd16);

    // full static region, then fill the table past its end
    set_static_size(11'd1024);
    for (int k = 0; k < smsr_pkg::DYN_ENTRIES + 6; k++)
      queue_access(smsr_pkg::FUNC_WRITE, 32'd1024 + k * 3, $urandom);
    for (int k = 0; k < smsr_pkg::DYN_ENTRIES + 6; k += 5)
      queue_access(smsr_pkg::FUNC_READ, 32'd1024 + k * 3, 32'h0);
    for (int k = 0; k < 8; k++)
      queue_access(smsr_pkg::FUNC_DELETE, 32'd1024 + k * 9, 32'h0);
    queue_access(smsr_pkg::FUNC_READ, 32'd1023, 32'h0);
    queue_access(smsr_pkg::FUNC_QUERY, 32'd1024, 32'h0);
    queue_random(120, 11'd1024);

    // size beyond the store depth
    set_static_size(11'd2047);
    queue_random(120, 11'd2047);

    // everything dynamic, hidden entries come back
    set_static_size(11'd0);
    queue_random(150, 11'd0);

    set_static_size(11'd1);
    queue_random(100, 11'd1);

    set_static_size(11'd1023);
    queue_random(100, 11'd1023);

    for (int p = 0; p < 2; p++) begin
      size_value = smsr_pkg::SIZE_W'($urandom_range(0, 2047));
      set_static_size(size_value);
      queue_random(150, size_value);
    end

    wait_idle();
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/smsr_pkg.sv
sv/smsr_front.sv
sv/smsr_queue.sv
sv/smsr_back.sv
sv/sparse_memory_with_static_region_unit.sv
test/sparse_memory_with_static_region_unit_tb.sv
